// ===== src/one_wire_bus_master_defines.svh =====
// Assertion macros for the 1-Wire bus master.
// Define NO_ASSERTIONS to compile them away.
`ifndef ONE_WIRE_BUS_MASTER_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Consequent checked in the same cycle as the antecedent.
`define OWBM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("one_wire_bus_master: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define OWBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("one_wire_bus_master: next-cycle check failed");

`else

`define OWBM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define OWBM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/owbm_pkg.sv =====
`timescale 1ns / 1ps

package owbm_pkg;

    localparam int TICK_W  = 10;
    localparam int NUM_REGS = 8;
    localparam int IDX_W   = $clog2(NUM_REGS);

    // Register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
    localparam logic [IDX_W-1:0] REG_WRITE_LOW     = 3'd3;
    localparam logic [IDX_W-1:0] REG_WRITE_HOLD    = 3'd4;
    localparam logic [IDX_W-1:0] REG_READ_LOW      = 3'd5;
    localparam logic [IDX_W-1:0] REG_READ_SAMPLE   = 3'd6;
    localparam logic [IDX_W-1:0] REG_READ_TAIL     = 3'd7;

    // Reset values of the tick registers
    localparam logic [TICK_W-1:0] RST_RESET_LOW     = 10'd500;
    localparam logic [TICK_W-1:0] RST_PRESENCE_WAIT = 10'd70;
    localparam logic [TICK_W-1:0] RST_RESET_TAIL    = 10'd500;
    localparam logic [TICK_W-1:0] RST_WRITE_LOW     = 10'd15;
    localparam logic [TICK_W-1:0] RST_WRITE_HOLD    = 10'd55;
    localparam logic [TICK_W-1:0] RST_READ_LOW      = 10'd10;
    localparam logic [TICK_W-1:0] RST_READ_SAMPLE   = 10'd10;
    localparam logic [TICK_W-1:0] RST_READ_TAIL     = 10'd55;

    // Command codes
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_RESET = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_TAIL = 4'd3,
        PH_WR_LOW   = 4'd4,
        PH_WR_HOLD  = 4'd5,
        PH_RD_LOW   = 4'd6,
        PH_RD_WAIT  = 4'd7,
        PH_RD_TAIL  = 4'd8
    } phase_t;

    typedef struct packed {
        logic [TICK_W-1:0] reset_low;
        logic [TICK_W-1:0] presence_wait;
        logic [TICK_W-1:0] reset_tail;
        logic [TICK_W-1:0] write_low;
        logic [TICK_W-1:0] write_hold;
        logic [TICK_W-1:0] read_low;
        logic [TICK_W-1:0] read_sample;
        logic [TICK_W-1:0] read_tail;
    } cfg_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
        logic       line_in;
    } item_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_data;
    } result_t;

    typedef struct packed {
        logic idle;
    } core_stat_t;

    // Tick register that sets the length of a busy phase
    function automatic logic [TICK_W-1:0] phase_len(cfg_t cfg, phase_t ph);
        logic [TICK_W-1:0] len;
        case (ph)
            PH_RST_LOW:  len = cfg.reset_low;
            PH_RST_WAIT: len = cfg.presence_wait;
            PH_RST_TAIL: len = cfg.reset_tail;
            PH_WR_LOW:   len = cfg.write_low;
            PH_WR_HOLD:  len = cfg.write_hold;
            PH_RD_LOW:   len = cfg.read_low;
            PH_RD_WAIT:  len = cfg.read_sample;
            default:     len = cfg.read_tail;
        endcase
        return len;
    endfunction

endpackage

// ===== src/owbm_ifs.sv =====
`timescale 1ns / 1ps

interface owbm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic       line_in;

    modport source (output valid, output operation, output data_byte, output line_in,
                    input ready);
    modport sink (input valid, input operation, input data_byte, input line_in,
                  output ready);
endinterface

interface owbm_out_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output presence, output read_data, input ready);
    modport sink (input valid, input drive_low, input busy_res, input done_res,
                  input presence, input read_data, output ready);
endinterface

// ===== src/one_wire_bus_master.sv =====
`timescale 1ns / 1ps

// 1-Wire bus master, stepped one bus tick per input word. Each input word carries an
// optional command (reset and presence, write byte, read byte), the byte to write, and
// the bus level sampled on that tick; each input word yields exactly one output word
// with the line drive, busy, a done pulse, the presence flag and the last byte read.
// Every slot timing is a tick count in eight 10-bit registers written through the
// cfg_* port; the user must write them only while the block is idle, which the block
// itself does not enforce. A count of zero acts as one tick. A command that arrives
// while a sequence is running is dropped. Throughput is one word per clock while the
// output is not stalled: the sequencer state updates once per word, and the path
// from the input register through the phase logic to the output register is
// combinational. A word passes through the input register and then the output
// register. A stalled output holds the sequencer and the input register, so the block holds at most two words.
`include "one_wire_bus_master_defines.svh"

module one_wire_bus_master
(
    input  logic                        clk,
    input  logic                        rst_n,
    owbm_in_if.sink                     in_ch,
    owbm_out_if.source                  out_ch,
    input  logic                        cfg_wr_en,
    input  logic [owbm_pkg::IDX_W-1:0]  cfg_index,
    input  logic [owbm_pkg::TICK_W-1:0] cfg_wr_data
);

    owbm_pkg::cfg_t       cfg;
    owbm_pkg::item_t      s1_item_reg;
    logic                 s1_valid_reg, s1_valid_next;
    owbm_pkg::result_t    res_next;
    owbm_pkg::result_t    res_reg;
    logic                 out_valid_reg, out_valid_next;
    owbm_pkg::core_stat_t core_stat;
    logic                 accept_in;
    logic                 advance;
    logic                 idle_tick;

    // Tick-count registers
    owbm_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_wr_en),
        .wr_index (cfg_index),
        .wr_data  (cfg_wr_data),
        .cfg      (cfg)
    );

    // Advance the sequencer when the input register holds a word and the output
    // register is empty or being drained this cycle.
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || advance;
    assign accept_in = in_ch.valid && in_ch.ready;

    always_comb
    begin
        if (accept_in)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Input and output registers: control with reset, payload without
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            s1_item_reg.operation <= in_ch.operation;
            s1_item_reg.data_byte <= in_ch.data_byte;
            s1_item_reg.line_in   <= in_ch.line_in;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // Phase sequencer: one tick of the bus per advance
    owbm_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (s1_item_reg),
        .cfg     (cfg),
        .res     (res_next),
        .stat    (core_stat)
    );

    // Output register drives the result channel
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.drive_low = res_reg.drive_low;
    assign out_ch.busy_res  = res_reg.busy_res;
    assign out_ch.done_res  = res_reg.done_res;
    assign out_ch.presence  = res_reg.presence;
    assign out_ch.read_data = res_reg.read_data;

    // A finishing tick leaves the sequencer idle.
    `OWBM_ASSERT_NEXT(a_done_then_idle, clk, rst_n, advance && res_next.done_res, core_stat.idle)
    // An idle tick with no command yields a word that is not busy.
    assign idle_tick = advance && core_stat.idle && s1_item_reg.operation == owbm_pkg::OP_NONE;
    `OWBM_ASSERT_NEXT(a_idle_not_busy, clk, rst_n, idle_tick, !res_reg.busy_res)
    // With the output register empty the input side never stalls.
    `OWBM_ASSERT_SAME(a_empty_ready, clk, rst_n, !out_valid_reg, in_ch.ready)

endmodule

// ===== src/owbm_cfg.sv =====
`timescale 1ns / 1ps

module owbm_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [owbm_pkg::IDX_W-1:0]  wr_index,
    input  logic [owbm_pkg::TICK_W-1:0] wr_data,
    output owbm_pkg::cfg_t              cfg
);

    owbm_pkg::cfg_t cfg_reg;
    owbm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                owbm_pkg::REG_RESET_LOW:     cfg_next.reset_low     = wr_data;
                owbm_pkg::REG_PRESENCE_WAIT: cfg_next.presence_wait = wr_data;
                owbm_pkg::REG_RESET_TAIL:    cfg_next.reset_tail    = wr_data;
                owbm_pkg::REG_WRITE_LOW:     cfg_next.write_low     = wr_data;
                owbm_pkg::REG_WRITE_HOLD:    cfg_next.write_hold    = wr_data;
                owbm_pkg::REG_READ_LOW:      cfg_next.read_low      = wr_data;
                owbm_pkg::REG_READ_SAMPLE:   cfg_next.read_sample   = wr_data;
                owbm_pkg::REG_READ_TAIL:     cfg_next.read_tail     = wr_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low     <= owbm_pkg::RST_RESET_LOW;
            cfg_reg.presence_wait <= owbm_pkg::RST_PRESENCE_WAIT;
            cfg_reg.reset_tail    <= owbm_pkg::RST_RESET_TAIL;
            cfg_reg.write_low     <= owbm_pkg::RST_WRITE_LOW;
            cfg_reg.write_hold    <= owbm_pkg::RST_WRITE_HOLD;
            cfg_reg.read_low      <= owbm_pkg::RST_READ_LOW;
            cfg_reg.read_sample   <= owbm_pkg::RST_READ_SAMPLE;
            cfg_reg.read_tail     <= owbm_pkg::RST_READ_TAIL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/owbm_core.sv =====
`timescale 1ns / 1ps

module owbm_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  owbm_pkg::item_t      item,
    input  owbm_pkg::cfg_t       cfg,
    output owbm_pkg::result_t    res,
    output owbm_pkg::core_stat_t stat
);

    owbm_pkg::phase_t            phase_reg, phase_next, ph;
    logic [owbm_pkg::TICK_W-1:0] tick_reg, tick_next, tick;
    logic [owbm_pkg::TICK_W-1:0] len;
    logic [2:0]                  bit_reg, bit_next, bidx;
    logic [7:0]                  shift_reg, shift_next, shft;
    logic                        presence_reg, presence_next;
    logic [7:0]                  read_reg, read_next;
    logic                        last;
    logic                        drive, busy, done;

    always_comb
    begin
        ph   = phase_reg;
        tick = tick_reg;
        bidx = bit_reg;
        shft = shift_reg;

        // A command taken while idle starts on this very tick
        if (phase_reg == owbm_pkg::PH_IDLE && item.operation != owbm_pkg::OP_NONE)
        begin
            tick = '0;
            bidx = '0;
            case (item.operation)
                owbm_pkg::OP_RESET: ph = owbm_pkg::PH_RST_LOW;
                owbm_pkg::OP_WRITE:
                begin
                    ph   = owbm_pkg::PH_WR_LOW;
                    shft = item.data_byte;
                end
                default:
                begin
                    ph   = owbm_pkg::PH_RD_LOW;
                    shft = '0;
                end
            endcase
        end

        len  = owbm_pkg::phase_len(cfg, ph);
        last = ({1'b0, tick} + 11'd1) >= {1'b0, len};

        phase_next    = ph;
        tick_next     = tick;
        bit_next      = bidx;
        shift_next    = shft;
        presence_next = presence_reg;
        read_next     = read_reg;
        drive         = 1'b0;
        busy          = 1'b0;
        done          = 1'b0;

        if (ph != owbm_pkg::PH_IDLE)
        begin
            busy = 1'b1;
            case (ph)
                owbm_pkg::PH_RST_LOW,
                owbm_pkg::PH_WR_LOW,
                owbm_pkg::PH_RD_LOW:  drive = 1'b1;
                owbm_pkg::PH_WR_HOLD: drive = ~shft[0];
                default:              drive = 1'b0;
            endcase

            if (last)
            begin
                tick_next = '0;
                case (ph)
                    owbm_pkg::PH_RST_LOW: phase_next = owbm_pkg::PH_RST_WAIT;
                    owbm_pkg::PH_RST_WAIT:
                    begin
                        presence_next = ~item.line_in;
                        phase_next    = owbm_pkg::PH_RST_TAIL;
                    end
                    owbm_pkg::PH_RST_TAIL:
                    begin
                        phase_next = owbm_pkg::PH_IDLE;
                        done       = 1'b1;
                    end
                    owbm_pkg::PH_WR_LOW: phase_next = owbm_pkg::PH_WR_HOLD;
                    owbm_pkg::PH_WR_HOLD:
                    begin
                        shift_next = {1'b0, shft[7:1]};
                        if (bidx == 3'd7)
                        begin
                            phase_next = owbm_pkg::PH_IDLE;
                            done       = 1'b1;
                            bit_next   = '0;
                        end
                        else
                        begin
                            bit_next   = bidx + 3'd1;
                            phase_next = owbm_pkg::PH_WR_LOW;
                        end
                    end
                    owbm_pkg::PH_RD_LOW: phase_next = owbm_pkg::PH_RD_WAIT;
                    owbm_pkg::PH_RD_WAIT:
                    begin
                        shift_next = {item.line_in, shft[7:1]};
                        phase_next = owbm_pkg::PH_RD_TAIL;
                    end
                    default:
                    begin
                        if (bidx == 3'd7)
                        begin
                            read_next  = shft;
                            phase_next = owbm_pkg::PH_IDLE;
                            done       = 1'b1;
                            bit_next   = '0;
                        end
                        else
                        begin
                            bit_next   = bidx + 3'd1;
                            phase_next = owbm_pkg::PH_RD_LOW;
                        end
                    end
                endcase
            end
            else
            begin
                tick_next = tick + 10'd1;
            end
        end

        res.drive_low = drive;
        res.busy_res  = busy;
        res.done_res  = done;
        res.presence  = presence_next;
        res.read_data = read_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= owbm_pkg::PH_IDLE;
            tick_reg     <= '0;
            bit_reg      <= '0;
            shift_reg    <= '0;
            presence_reg <= 1'b0;
            read_reg     <= '0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            bit_reg      <= bit_next;
            shift_reg    <= shift_next;
            presence_reg <= presence_next;
            read_reg     <= read_next;
        end
    end

    assign stat.idle = (phase_reg == owbm_pkg::PH_IDLE);

endmodule

// ===== dv/owbm_checker.sv =====
`timescale 1ns / 1ps

module owbm_checker
    import owbm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    owbm_in_if                in_mon,
    owbm_out_if               out_mon,
    input  logic              cfg_wr_en,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [TICK_W-1:0] cfg_wr_data,
    output logic              seq_idle,
    output int                pending_words,
    output int                fail_count
);

    // Mirror of the sequencer
    logic [TICK_W-1:0] tick_regs [NUM_REGS];
    phase_t            seq_phase;
    logic [TICK_W-1:0] phase_ticks;
    logic [2:0]        slot_index;
    logic [7:0]        slot_byte;
    logic              presence_q;
    logic [7:0]        last_read;

    result_t           expected_words [$];

    function automatic logic [TICK_W-1:0] slot_length(phase_t ph);
        case (ph)
            PH_RST_LOW:  return tick_regs[REG_RESET_LOW];
            PH_RST_WAIT: return tick_regs[REG_PRESENCE_WAIT];
            PH_RST_TAIL: return tick_regs[REG_RESET_TAIL];
            PH_WR_LOW:   return tick_regs[REG_WRITE_LOW];
            PH_WR_HOLD:  return tick_regs[REG_WRITE_HOLD];
            PH_RD_LOW:   return tick_regs[REG_READ_LOW];
            PH_RD_WAIT:  return tick_regs[REG_READ_SAMPLE];
            default:     return tick_regs[REG_READ_TAIL];
        endcase
    endfunction

    task automatic reset_sequencer();
        tick_regs[REG_RESET_LOW]     = RST_RESET_LOW;
        tick_regs[REG_PRESENCE_WAIT] = RST_PRESENCE_WAIT;
        tick_regs[REG_RESET_TAIL]    = RST_RESET_TAIL;
        tick_regs[REG_WRITE_LOW]     = RST_WRITE_LOW;
        tick_regs[REG_WRITE_HOLD]    = RST_WRITE_HOLD;
        tick_regs[REG_READ_LOW]      = RST_READ_LOW;
        tick_regs[REG_READ_SAMPLE]   = RST_READ_SAMPLE;
        tick_regs[REG_READ_TAIL]     = RST_READ_TAIL;
        seq_phase   = PH_IDLE;
        phase_ticks = '0;
        slot_index  = '0;
        slot_byte   = '0;
        presence_q  = 1'b0;
        last_read   = '0;
    endtask

    // Advance the mirror by one bus tick and return the word it must produce
    task automatic advance_tick(input item_t word, output result_t res);
        logic [TICK_W:0] span;
        logic            last_tick;
        res = '0;
        if (seq_phase == PH_IDLE && word.operation != OP_NONE) begin
            phase_ticks = '0;
            slot_index  = '0;
            case (word.operation)
                OP_RESET: seq_phase = PH_RST_LOW;
                OP_WRITE:
                begin
                    seq_phase = PH_WR_LOW;
                    slot_byte = word.data_byte;
                end
                default:
                begin
                    seq_phase = PH_RD_LOW;
                    slot_byte = '0;
                end
            endcase
        end
        if (seq_phase != PH_IDLE) begin
            res.busy_res = 1'b1;
            span      = {1'b0, phase_ticks} + 1'b1;
            last_tick = span >= {1'b0, slot_length(seq_phase)};
            case (seq_phase)
                PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: res.drive_low = 1'b1;
                PH_WR_HOLD:                       res.drive_low = ~slot_byte[0];
                default:                          res.drive_low = 1'b0;
            endcase
            if (last_tick) begin
                phase_ticks = '0;
                case (seq_phase)
                    PH_RST_LOW:  seq_phase = PH_RST_WAIT;
                    PH_RST_WAIT:
                    begin
                        presence_q = ~word.line_in;
                        seq_phase  = PH_RST_TAIL;
                    end
                    PH_RST_TAIL:
                    begin
                        seq_phase    = PH_IDLE;
                        res.done_res = 1'b1;
                    end
                    PH_WR_LOW:   seq_phase = PH_WR_HOLD;
                    PH_WR_HOLD:
                    begin
                        slot_byte = slot_byte >> 1;
                        if (slot_index == 3'd7) begin
                            seq_phase    = PH_IDLE;
                            res.done_res = 1'b1;
                            slot_index   = '0;
                        end else begin
                            slot_index = slot_index + 1'b1;
                            seq_phase  = PH_WR_LOW;
                        end
                    end
                    PH_RD_LOW:   seq_phase = PH_RD_WAIT;
                    PH_RD_WAIT:
                    begin
                        slot_byte = {word.line_in, slot_byte[7:1]};
                        seq_phase = PH_RD_TAIL;
                    end
                    default:
                    begin
                        if (slot_index == 3'd7) begin
                            last_read    = slot_byte;
                            seq_phase    = PH_IDLE;
                            res.done_res = 1'b1;
                            slot_index   = '0;
                        end else begin
                            slot_index = slot_index + 1'b1;
                            seq_phase  = PH_RD_LOW;
                        end
                    end
                endcase
            end else begin
                phase_ticks = phase_ticks + 1'b1;
            end
        end
        res.presence  = presence_q;
        res.read_data = last_read;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : monitor
        result_t want;
        if (!rst_n) begin
            reset_sequencer();
            expected_words.delete();
            pending_words = 0;
            fail_count    = 0;
            seq_idle     <= 1'b1;
        end else begin
            if (cfg_wr_en) begin
                tick_regs[cfg_index] = cfg_wr_data;
            end
            if (out_mon.valid && out_mon.ready) begin
                if (expected_words.size() == 0) begin
                    $error("output word with nothing expected");
                    fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("drive_low", 8'(want.drive_low), 8'(out_mon.drive_low));
                    check_field("busy_res", 8'(want.busy_res), 8'(out_mon.busy_res));
                    check_field("done_res", 8'(want.done_res), 8'(out_mon.done_res));
                    check_field("presence", 8'(want.presence), 8'(out_mon.presence));
                    check_field("read_data", want.read_data, out_mon.read_data);
                end
            end
            if (in_mon.valid && in_mon.ready) begin
                advance_tick('{operation: in_mon.operation, data_byte: in_mon.data_byte,
                               line_in: in_mon.line_in}, want);
                expected_words.push_back(want);
            end
            pending_words = expected_words.size();
            seq_idle     <= (seq_phase == PH_IDLE);
        end
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import owbm_pkg::*;

    // Random bus ticks after the directed part
    localparam int RANDOM_TICKS = 300;
    localparam int TICKS_PER_PHASE = 100;
    // Long receiver hold-off, long enough to fill the block and stall its input
    localparam int HOLD_CYCLES = 300;

    typedef enum int {LINE_LOW, LINE_HIGH, LINE_RANDOM} line_mode_e;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [IDX_W-1:0]  cfg_index;
    logic [TICK_W-1:0] cfg_wr_data;

    logic              seq_idle;
    int                pending_words;
    int                fail_count;

    // Set to run both sides without any idling
    bit                quiet_link;
    // Raised once to make the receiver hold off for a long stretch
    logic              rx_hold_req;

    owbm_in_if  in_ch ();
    owbm_out_if out_ch ();

    one_wire_bus_master i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    owbm_checker i_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_mon        (in_ch),
        .out_mon       (out_ch),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .seq_idle      (seq_idle),
        .pending_words (pending_words),
        .fail_count    (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #10ms;
        $display("*** FAILED ***");
        $finish;
    end

    // Gap length for either side: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        if (quiet_link) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return 0;
        end
        if (roll < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    function automatic logic line_level(line_mode_e mode);
        case (mode)
            LINE_LOW:  return 1'b0;
            LINE_HIGH: return 1'b1;
            default:   return 1'($urandom_range(0, 1));
        endcase
    endfunction

    // Same tick count in every register
    function automatic cfg_t flat_timing(logic [TICK_W-1:0] ticks);
        return cfg_t'({NUM_REGS{ticks}});
    endfunction

    // Mostly short phases so many sequences fit; now and then zero or longer
    function automatic logic [TICK_W-1:0] random_ticks();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            return '0;
        end
        if (roll < 20) begin
            return 10'd1;
        end
        if (roll < 90) begin
            return 10'($urandom_range(2, 6));
        end
        return 10'($urandom_range(7, 40));
    endfunction

    function automatic cfg_t random_timing();
        cfg_t t;
        t.reset_low     = random_ticks();
        t.presence_wait = random_ticks();
        t.reset_tail    = random_ticks();
        t.write_low     = random_ticks();
        t.write_hold    = random_ticks();
        t.read_low      = random_ticks();
        t.read_sample   = random_ticks();
        t.read_tail     = random_ticks();
        return t;
    endfunction

    // Raise the write strobe and wait for the next edge; the caller drops it after the burst
    task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [TICK_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(posedge clk);
    endtask

    task automatic program_timing(input cfg_t t);
        put_reg(REG_RESET_LOW, t.reset_low);
        put_reg(REG_PRESENCE_WAIT, t.presence_wait);
        put_reg(REG_RESET_TAIL, t.reset_tail);
        put_reg(REG_WRITE_LOW, t.write_low);
        put_reg(REG_WRITE_HOLD, t.write_hold);
        put_reg(REG_READ_LOW, t.read_low);
        put_reg(REG_READ_SAMPLE, t.read_sample);
        put_reg(REG_READ_TAIL, t.read_tail);
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one tick word and return at the edge that accepts it. Valid stays
    // high afterwards so back-to-back words need no gap.
    task automatic send_tick(input logic [1:0] op, input logic [7:0] data, input logic line);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.data_byte <= data;
        in_ch.line_in   <= line;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Feed empty ticks until the sequencer is back in idle. The idle flag seen at
    // an accept edge covers every word before the one just accepted; that one is
    // empty, so it cannot start anything new.
    task automatic settle(input line_mode_e mode);
        do
            send_tick(OP_NONE, 8'($urandom_range(0, 255)), line_level(mode));
        while (!seq_idle);
    endtask

    task automatic run_sequence(input logic [1:0] op, input logic [7:0] data,
                                input line_mode_e mode);
        send_tick(op, data, line_level(mode));
        settle(mode);
    endtask

    // Pause the sender until every expected word is back, then realign to an edge
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_words != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic [1:0] random_op();
        if ($urandom_range(0, 99) < 75) begin
            return OP_NONE;
        end
        return 2'($urandom_range(1, 3));
    endfunction

    // Output side: random stalls, plus one long hold-off on request
    initial
    begin : receiver
        int stall;
        bit held;
        stall = 0;
        held  = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_req && !held) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held = 1'b1;
            end else if (stall > 0) begin
                out_ch.ready <= 1'b0;
                stall--;
            end else begin
                out_ch.ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    initial
    begin : stimulus
        int sent;
        int phase_no;

        quiet_link = 1'b0;
        rst_n           <= 1'b0;
        rx_hold_req     <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.operation <= OP_NONE;
        in_ch.data_byte <= '0;
        in_ch.line_in   <= 1'b1;
        cfg_wr_en       <= 1'b0;
        cfg_index       <= REG_RESET_LOW;
        cfg_wr_data     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Keep the reset timing of presence wait, write low, read low and read
        // sample; cut the long phases to one tick so the sequences stay short
        put_reg(REG_RESET_LOW, 10'd1);
        put_reg(REG_RESET_TAIL, 10'd1);
        put_reg(REG_WRITE_HOLD, 10'd1);
        put_reg(REG_READ_TAIL, 10'd1);
        cfg_wr_en <= 1'b0;
        run_sequence(OP_RESET, 8'h00, LINE_LOW);
        run_sequence(OP_WRITE, 8'h5A, LINE_RANDOM);
        run_sequence(OP_READ, 8'h00, LINE_RANDOM);
        drain();

        // Shortest legal timing: presence and absence, write and read extremes
        program_timing(flat_timing(10'd1));
        run_sequence(OP_RESET, 8'h00, LINE_LOW);
        run_sequence(OP_RESET, 8'hFF, LINE_HIGH);
        run_sequence(OP_WRITE, 8'h00, LINE_RANDOM);
        run_sequence(OP_WRITE, 8'hFF, LINE_RANDOM);
        run_sequence(OP_WRITE, 8'hA5, LINE_RANDOM);
        run_sequence(OP_READ, 8'h00, LINE_LOW);
        run_sequence(OP_READ, 8'hFF, LINE_HIGH);
        run_sequence(OP_READ, 8'h3C, LINE_RANDOM);
        // Random commands that land on a running sequence must be dropped; once idle
        // they start a new one
        send_tick(OP_READ, 8'h00, 1'b0);
        repeat (40) begin
            send_tick(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      line_level(LINE_RANDOM));
        end
        settle(LINE_RANDOM);
        drain();

        // A tick count of zero behaves as one tick
        program_timing(flat_timing('0));
        run_sequence(OP_RESET, 8'h00, LINE_LOW);
        run_sequence(OP_WRITE, 8'hC3, LINE_RANDOM);
        run_sequence(OP_READ, 8'h00, LINE_RANDOM);
        drain();

        // Random phases: new timing each time, mostly empty ticks with random
        // commands, many of them landing on a busy sequencer
        sent = 0;
        phase_no = 0;
        while (sent < RANDOM_TICKS)
        begin
            program_timing(random_timing());
            quiet_link = (phase_no % 4 == 3);
            if (phase_no == 2) begin
                rx_hold_req <= 1'b1;
            end
            repeat (TICKS_PER_PHASE) begin
                send_tick(random_op(), 8'($urandom_range(0, 255)), line_level(LINE_RANDOM));
                sent++;
            end
            settle(LINE_RANDOM);
            drain();
            phase_no++;
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending_words == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== one_wire_bus_master.f =====
+incdir+src
src/owbm_pkg.sv
src/owbm_ifs.sv
src/owbm_cfg.sv
src/owbm_core.sv
src/one_wire_bus_master.sv
dv/owbm_checker.sv
dv/tb_top.sv
